### hw/rtl/tpaq_pkg.sv
// Shared types and constants for the two-level priority action queue.
package tpaq_pkg;

	localparam int ACT_W            = 8;
	localparam int POS_W            = 6;
	localparam int CMD_W            = 2;
	localparam int URGENT_DEPTH_DEF = 8;
	localparam int NORMAL_DEPTH_DEF = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_e;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic commit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_stall;
	} dp_stat_t;

endpackage

### hw/rtl/two_level_priority_action_queue.sv
// A request is accepted and captured, the rings are read, then the result is committed
// to the output register; a new request is accepted only after that commit.
// The commit step waits while the previous result is not yet taken.
// Reset clears the ring pointers, the no-action code and the control state.
// Ring contents are undefined after reset; there is no clearing pass.
// Top level: urgent and normal action rings with a shared no-action code.
module two_level_priority_action_queue #(
	parameter int URGENT_DEPTH = tpaq_pkg::URGENT_DEPTH_DEF,
	parameter int NORMAL_DEPTH = tpaq_pkg::NORMAL_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // action_in[7:0], position[13:8], zero pad
	input  logic [2:0]  s_tuser,   // command[1:0], urgent[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // action_out[7:0], push_ok[8], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // no_action_code
);
	import tpaq_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	tpaq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tpaq_dp #(
		.URGENT_DEPTH (URGENT_DEPTH),
		.NORMAL_DEPTH (NORMAL_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data)
	);

`ifndef ASSERT_OFF
	// one request at a time: no accept right after an accept
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while the previous one is in flight");

	// once the ring read is done the request commits unless the output is stalled
	a_commit_timing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 (cmd.commit || stat.out_stall))
		else $error("request did not reach commit on time");

	// a successful push reports action code zero
	a_push_ok_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
		else $error("push_ok set with a nonzero action");

	// a commit never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid && !m_tready))
		else $error("result overwritten before it was taken");
`endif

endmodule

### hw/rtl/tpaq_ctrl.sv
// Sequencer: accept a request, read the rings, commit the result.
module tpaq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  tpaq_pkg::dp_stat_t    stat,
	output tpaq_pkg::ctrl_cmd_t   cmd
);
	import tpaq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_READ   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.commit  = 1'b0;
		s_tready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold while the previous result is still waiting
				if (!stat.out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/tpaq_dp.sv
// Datapath: ring pointers, ring memories, no-action register and output register.
module tpaq_dp #(
	parameter int URGENT_DEPTH = tpaq_pkg::URGENT_DEPTH_DEF,
	parameter int NORMAL_DEPTH = tpaq_pkg::NORMAL_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tpaq_pkg::ctrl_cmd_t   cmd,
	output tpaq_pkg::dp_stat_t    stat,
	input  logic [15:0]           s_tdata,
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,
	input  logic                  cfg_valid,
	input  logic [tpaq_pkg::ACT_W-1:0] cfg_data
);
	import tpaq_pkg::*;

	localparam int UW = $clog2(URGENT_DEPTH);
	localparam int NW = $clog2(NORMAL_DEPTH);
	localparam int EW = POS_W + 1;

	localparam logic [UW-1:0] U_LAST  = UW'(URGENT_DEPTH - 1);
	localparam logic [NW-1:0] N_LAST  = NW'(NORMAL_DEPTH - 1);
	localparam logic [UW-1:0] U_DEP_M = UW'(URGENT_DEPTH);
	localparam logic [NW-1:0] N_DEP_M = NW'(NORMAL_DEPTH);
	localparam logic [EW-1:0] U_DEP_E = EW'(URGENT_DEPTH);
	localparam logic [EW-1:0] N_DEP_E = EW'(NORMAL_DEPTH);

	// captured request
	cmd_e             cmd_q;
	logic             urg_q;
	logic [ACT_W-1:0] act_q;
	logic [POS_W-1:0] pos_q;

	logic [UW-1:0]    uh_q, ut_q;
	logic [NW-1:0]    nh_q, nt_q;
	logic [ACT_W-1:0] code_q;

	logic [ACT_W-1:0] umem [URGENT_DEPTH];
	logic [ACT_W-1:0] nmem [NORMAL_DEPTH];
	logic [ACT_W-1:0] rd_u_q, rd_n_q;

	logic             out_valid_q;
	logic [ACT_W-1:0] out_act_q;
	logic             out_ok_q;

	logic [UW-1:0]    uh_inc, ut_inc, uq, u_addr, u_rd_addr, u_wr_addr;
	logic [NW-1:0]    nh_inc, nt_inc, nq, n_addr, n_rd_addr, n_wr_addr;
	logic [EW-1:0]    pos_x, uq_x, nq_x, rel, u_sum, n_sum, u_addr_x, n_addr_x;
	logic             u_empty, n_empty, u_full, n_full, u_hit, n_hit;
	logic [ACT_W-1:0] u_val, wdata, res;
	logic             ok, u_we, n_we, pop_u, pop_n;

	always_comb begin
		uh_inc  = (uh_q == U_LAST) ? '0 : uh_q + 1'b1;
		ut_inc  = (ut_q == U_LAST) ? '0 : ut_q + 1'b1;
		nh_inc  = (nh_q == N_LAST) ? '0 : nh_q + 1'b1;
		nt_inc  = (nt_q == N_LAST) ? '0 : nt_q + 1'b1;
		// pointers wrap at the ring depth; add it back only when the tail has wrapped
		uq      = (ut_q >= uh_q) ? ut_q - uh_q : ut_q - uh_q + U_DEP_M;
		nq      = (nt_q >= nh_q) ? nt_q - nh_q : nt_q - nh_q + N_DEP_M;
		u_empty = (uh_q == ut_q);
		n_empty = (nh_q == nt_q);
		u_full  = (ut_inc == uh_q);
		n_full  = (nt_inc == nh_q);

		pos_x    = {1'b0, pos_q};
		uq_x     = EW'(uq);
		nq_x     = EW'(nq);
		rel      = pos_x - uq_x;
		u_hit    = (pos_x < uq_x);
		n_hit    = (rel < nq_x);
		// sums stay below twice the depth when the entry exists
		u_sum    = pos_x + EW'(uh_q);
		n_sum    = rel + EW'(nh_q);
		u_addr_x = (u_sum >= U_DEP_E) ? u_sum - U_DEP_E : u_sum;
		n_addr_x = (n_sum >= N_DEP_E) ? n_sum - N_DEP_E : n_sum;
		u_addr   = u_addr_x[UW-1:0];
		n_addr   = n_addr_x[NW-1:0];

		u_rd_addr = (cmd_q == CMD_POP) ? uh_q : u_addr;
		n_rd_addr = (cmd_q == CMD_POP) ? nh_q : n_addr;
		u_wr_addr = (cmd_q == CMD_PUSH) ? ut_q : u_addr;
		n_wr_addr = (cmd_q == CMD_PUSH) ? nt_q : n_addr;
		wdata     = (cmd_q == CMD_PUSH) ? act_q : code_q;

		u_val = u_empty ? code_q : rd_u_q;
		pop_u = 1'b0;
		pop_n = 1'b0;
		u_we  = 1'b0;
		n_we  = 1'b0;
		res   = '0;
		ok    = 1'b0;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (urg_q) begin
					ok   = !u_full;
					u_we = !u_full;
				end else begin
					ok   = !n_full;
					n_we = !n_full;
				end
			end
			CMD_POP: begin
				pop_u = !u_empty;
				res   = u_val;
				// urgent side empty or holding the no-action code: take normal head
				if (u_val == code_q) begin
					pop_n = !n_empty;
					res   = n_empty ? code_q : rd_n_q;
				end
			end
			CMD_PEEK: begin
				if (u_hit)      res = rd_u_q;
				else if (n_hit) res = rd_n_q;
				else            res = code_q;
			end
			CMD_DELETE: begin
				u_we = u_hit;
				n_we = !u_hit && n_hit;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uh_q        <= '0;
			ut_q        <= '0;
			nh_q        <= '0;
			nt_q        <= '0;
			code_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				code_q <= cfg_data;
			end
			if (cmd.commit) begin
				if (cmd_q == CMD_PUSH && u_we) ut_q <= ut_inc;
				if (cmd_q == CMD_PUSH && n_we) nt_q <= nt_inc;
				if (pop_u) uh_q <= uh_inc;
				if (pop_n) nh_q <= nh_inc;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= cmd_e'(s_tuser[CMD_W-1:0]);
			urg_q <= s_tuser[CMD_W];
			act_q <= s_tdata[ACT_W-1:0];
			pos_q <= s_tdata[ACT_W+POS_W-1:ACT_W];
		end
		if (cmd.commit) begin
			out_act_q <= res;
			out_ok_q  <= ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && u_we) begin
			umem[u_wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_u_q <= umem[u_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && n_we) begin
			nmem[n_wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_n_q <= nmem[n_rd_addr];
		end
	end

	assign stat.out_stall = out_valid_q && !m_tready;
	assign m_tvalid       = out_valid_q;
	assign m_tdata        = {7'd0, out_ok_q, out_act_q};

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the two-level priority action queue.
module testbench;
	import tpaq_pkg::*;

	localparam int URGENT_DEPTH = URGENT_DEPTH_DEF;
	localparam int NORMAL_DEPTH = NORMAL_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic             push_ok;
		logic [ACT_W-1:0] action;
	} reply_t;

	// Shadow copy of both rings; predicts one reply per accepted request.
	class action_queue_shadow;
		logic [ACT_W-1:0] urgent_ring [URGENT_DEPTH];
		logic [ACT_W-1:0] normal_ring [NORMAL_DEPTH];
		int unsigned      u_head, u_tail, n_head, n_tail;
		logic [ACT_W-1:0] idle_code;
		reply_t           pending_replies [$];
		int               errors;

		function new();
			u_head    = 0;
			u_tail    = 0;
			n_head    = 0;
			n_tail    = 0;
			idle_code = '0;
			errors    = 0;
		endfunction

		function int unsigned urgent_count();
			return (u_tail + URGENT_DEPTH - u_head) % URGENT_DEPTH;
		endfunction

		function int unsigned normal_count();
			return (n_tail + NORMAL_DEPTH - n_head) % NORMAL_DEPTH;
		endfunction

		function void note_request(cmd_e cmd, logic urg, logic [ACT_W-1:0] act,
				logic [POS_W-1:0] pos);
			reply_t      r;
			int unsigned uq, nq, p;
			r  = '0;
			uq = urgent_count();
			nq = normal_count();
			p  = pos;
			case (cmd)
			CMD_PUSH: begin
				if (urg) begin
					if ((u_tail + 1) % URGENT_DEPTH != u_head) begin
						urgent_ring[u_tail] = act;
						u_tail    = (u_tail + 1) % URGENT_DEPTH;
						r.push_ok = 1'b1;
					end
				end else begin
					if ((n_tail + 1) % NORMAL_DEPTH != n_head) begin
						normal_ring[n_tail] = act;
						n_tail    = (n_tail + 1) % NORMAL_DEPTH;
						r.push_ok = 1'b1;
					end
				end
			end
			CMD_POP: begin
				r.action = idle_code;
				if (uq != 0) begin
					r.action = urgent_ring[u_head];
					u_head   = (u_head + 1) % URGENT_DEPTH;
				end
				// an empty or cancelled urgent head falls through to the normal ring
				if (r.action == idle_code && nq != 0) begin
					r.action = normal_ring[n_head];
					n_head   = (n_head + 1) % NORMAL_DEPTH;
				end
			end
			CMD_PEEK: begin
				if (p < uq)
					r.action = urgent_ring[(u_head + p) % URGENT_DEPTH];
				else if (p - uq < nq)
					r.action = normal_ring[(n_head + p - uq) % NORMAL_DEPTH];
				else
					r.action = idle_code;
			end
			default: begin
				if (p < uq)
					urgent_ring[(u_head + p) % URGENT_DEPTH] = idle_code;
				else if (p - uq < nq)
					normal_ring[(n_head + p - uq) % NORMAL_DEPTH] = idle_code;
			end
			endcase
			pending_replies.push_back(r);
		endfunction

		function void check_result(logic [15:0] data);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, data);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			if (data[7:0] !== want.action) begin
				$display("%0t: action_out mismatch, expected %h, actual %h",
					$time, want.action, data[7:0]);
				errors++;
			end
			if (data[8] !== want.push_ok) begin
				$display("%0t: push_ok mismatch, expected %b, actual %b",
					$time, want.push_ok, data[8]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // action_in[7:0], position[13:8], zero pad
	logic [2:0]  s_tuser;   // command[1:0], urgent[2]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // action_out[7:0], push_ok[8], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;  // no_action_code

	action_queue_shadow shadow;
	int                 cycle_count = 0;
	int                 stall_mode  = 0;
	int                 stall_left  = 0;

	two_level_priority_action_queue #(
		.URGENT_DEPTH(URGENT_DEPTH),
		.NORMAL_DEPTH(NORMAL_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			shadow.check_result(m_tdata);
	end

	// receiver back-pressure: windows of random length, each with a randomly chosen pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(8, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= 1'($urandom_range(0, 1));
		2: m_tready <= (stall_left % 6) < 2;
		default: m_tready <= stall_left > 12;
		endcase
	end

	task automatic send_request(cmd_e cmd, logic urg, logic [ACT_W-1:0] act,
			logic [POS_W-1:0] pos);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= {urg, cmd};
		s_tdata  <= {2'b00, pos, act};
		do @(posedge clk); while (!s_tready);
		shadow.note_request(cmd, urg, act, pos);
	endtask

	task automatic idle_gap(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tuser  <= 3'($urandom);
		s_tdata  <= 16'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// stop sending and let every outstanding reply come back
	task automatic drain();
		idle_gap(1);
		while (shadow.pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_no_action(logic [7:0] code);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= code;
		do @(posedge clk); while (!cfg_ready);
		shadow.idle_code = code;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= 8'($urandom);
	endtask

	task automatic random_request(int push_pct);
		int               r, span;
		cmd_e             cmd;
		logic             urg;
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			cmd = CMD_PUSH;
		else if (r % 3 == 0)
			cmd = CMD_POP;
		else if (r % 3 == 1)
			cmd = CMD_PEEK;
		else
			cmd = CMD_DELETE;
		urg = $urandom_range(0, 99) < 35;
		// reuse the no-action code often so pops exercise the fall-through
		act = ($urandom_range(0, 3) == 0) ? shadow.idle_code : 8'($urandom_range(0, 255));
		span = shadow.urgent_count() + shadow.normal_count() + 2;
		pos = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, span));
		send_request(cmd, urg, act, pos);
	endtask

	task automatic random_phase(int n, int push_pct);
		int sent, burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < n; k++) begin
				random_request(push_pct);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 8));
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		shadow    = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset no-action code
		send_request(CMD_POP,    1'b0, 8'h00, 6'd0);
		send_request(CMD_PEEK,   1'b1, 8'hFF, 6'd0);
		send_request(CMD_DELETE, 1'b0, 8'h00, 6'd63);
		send_request(CMD_PUSH,   1'b1, 8'hFF, 6'd0);
		send_request(CMD_PUSH,   1'b1, 8'h00, 6'd0);
		for (int i = 1; i <= 6; i++)
			send_request(CMD_PUSH, 1'b1, 8'(i), 6'd0);
		// urgent ring now full: this one is dropped
		send_request(CMD_PUSH,   1'b1, 8'h77, 6'd63);
		send_request(CMD_PUSH,   1'b0, 8'hA5, 6'd0);
		send_request(CMD_PEEK,   1'b0, 8'h00, 6'd0);
		send_request(CMD_PEEK,   1'b0, 8'h00, 6'd7);
		send_request(CMD_PEEK,   1'b0, 8'h00, 6'd8);
		send_request(CMD_PEEK,   1'b1, 8'hFF, 6'd63);
		send_request(CMD_DELETE, 1'b0, 8'h00, 6'd0);
		send_request(CMD_POP,    1'b0, 8'h00, 6'd0);
		send_request(CMD_POP,    1'b1, 8'hFF, 6'd63);
		send_request(CMD_DELETE, 1'b1, 8'hFF, 6'd8);
		send_request(CMD_PEEK,   1'b0, 8'h00, 6'd2);
		send_request(CMD_PUSH,   1'b1, 8'h5A, 6'd63);
		send_request(CMD_PEEK,   1'b0, 8'h00, 6'd5);

		write_no_action(8'hFF);
		random_phase(350, 80);
		write_no_action(8'($urandom_range(1, 254)));
		random_phase(350, 40);
		write_no_action(8'h00);
		random_phase(350, 65);
		write_no_action(8'($urandom_range(0, 255)));
		random_phase(350, 25);
		write_no_action(8'hFF);
		random_phase(350, 55);

		drain();
		if (shadow.errors == 0 && shadow.pending_replies.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
